>>> rtl/path_clip_window_by_arc_length_assert.svh
// assertion macros for the path clip window block
`ifndef PATH_CLIP_WINDOW_BY_ARC_LENGTH_ASSERT_SVH
`define PATH_CLIP_WINDOW_BY_ARC_LENGTH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/pcw_pkg.sv
// shared types and constants for the path clip window block
package pcw_pkg;
    localparam int unsigned LEN_W = 20;
    localparam int unsigned IDX_OUT_W = 10;
    localparam int unsigned SQ_W = 66;
    localparam int unsigned ROOT_W = 34;
    localparam int unsigned SUM_W = 48;
    localparam logic [LEN_W-1:0] FWD_RESET = 20'd100000;
    localparam logic [LEN_W-1:0] BWD_RESET = 20'd5000;
    localparam logic [0:0] REG_FWD = 1'b0;
    localparam logic [0:0] REG_BWD = 1'b1;
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_CLIP = 1'b1;
endpackage

>>> rtl/pcw_sqrt.sv
// bit-serial integer square root of a squared segment length
module pcw_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcw_pkg::SQ_W-1:0]     i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [pcw_pkg::ROOT_W-1:0]   o_root
);
    import pcw_pkg::*;

    logic [SQ_W-1:0]   r_rem, n_rem;
    logic [SQ_W-1:0]   r_res, n_res;
    logic [SQ_W-1:0]   r_bit, n_bit;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SQ_W-1:0]   w_try;

    assign w_try = r_res + r_bit;

    always_comb begin
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_value;
            n_res  = '0;
            n_bit  = {2'b01, {(SQ_W-2){1'b0}}};
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= w_try) begin
                n_rem = r_rem - w_try;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule

>>> rtl/path_clip_window_by_arc_length.sv
// top level of the path clip window block: point store and query sequencer
//
// loads a polyline one point per transfer and answers window clip queries
// input transfer: start high while busy low; i_func selects append or clip
// an append gives no result and leaves the block ready
// a clip query on n >= 3 points scans the store for the nearest point
// (read, square both differences, sum and compare per point), then walks
// once for the window start and once for the window end; a walk step reads
// the neighbor, squares the length on the shared multiplier, takes its root
// in the shared square root unit, then sums and compares
// a clip on fewer than 3 points keeps busy high for one cycle only
// the result is on o_start_index, o_end_index, o_was_clipped and
// o_overflowed for one cycle marked by o_valid, in the same cycle that busy falls;
// the receiver cannot stall; one query is finished before the next starts
// configuration: i_cfg_we, i_cfg_index, i_cfg_data; written while idle
// reset is synchronous and active low; it empties the path, clears the
// overflow flag and restores the default lengths; the point store itself
// is not cleared and only entries below the point count are ever read
module path_clip_window_by_arc_length #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic signed [31:0]                 i_coord_x,
    input  logic signed [31:0]                 i_coord_y,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [pcw_pkg::LEN_W-1:0]          i_cfg_data,
    output logic                               o_valid,
    output logic [pcw_pkg::IDX_OUT_W-1:0]      o_start_index,
    output logic [pcw_pkg::IDX_OUT_W-1:0]      o_end_index,
    output logic                               o_was_clipped,
    output logic                               o_overflowed
);
    import pcw_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = COORD_WIDTH + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SRD   = 5'd1;
    localparam logic [4:0] S_SLAT  = 5'd2;
    localparam logic [4:0] S_DX    = 5'd3;
    localparam logic [4:0] S_DY    = 5'd4;
    localparam logic [4:0] S_DSUM  = 5'd5;
    localparam logic [4:0] S_SCMP  = 5'd6;
    localparam logic [4:0] S_WINIT = 5'd7;
    localparam logic [4:0] S_ARD   = 5'd8;
    localparam logic [4:0] S_ALAT  = 5'd9;
    localparam logic [4:0] S_WCHK  = 5'd10;
    localparam logic [4:0] S_BRD   = 5'd11;
    localparam logic [4:0] S_BLAT  = 5'd12;
    localparam logic [4:0] S_RGO   = 5'd13;
    localparam logic [4:0] S_RWAIT = 5'd14;
    localparam logic [4:0] S_WCMP  = 5'd15;
    localparam logic [4:0] S_WFIN  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [COORD_WIDTH-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_WIDTH-1:0] r_mem_y [MAX_POINTS];
    logic [COORD_WIDTH-1:0] r_rd_x, r_rd_y;
    logic [AW-1:0]          w_rd_addr;

    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic [LEN_W-1:0] r_fwd, r_bwd;
    logic [4:0]       r_state, n_state;

    logic [COORD_WIDTH-1:0] r_ax, r_ay;
    logic [COORD_WIDTH-1:0] r_bx, r_by;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_best, r_cur;
    logic [AW-1:0]    r_res_idx;
    logic [SQ_W-1:0]  r_bestd, r_acc;
    logic [DW-1:0]    r_mag;
    logic             r_walking;
    logic             r_pass;
    logic             r_dir;
    logic [SUM_W-1:0] r_sum;
    logic [LEN_W-1:0] r_limit;
    logic [AW-1:0]    r_start_idx, r_end_idx;
    logic             r_valid;
    logic             r_clipped;

    logic [2*DW-1:0]  w_sq;
    logic             w_accept;
    logic             w_append;
    logic             w_full;
    logic [ROOT_W-1:0] w_root;
    logic [DW-1:0]    w_dx, w_dy;
    logic [DW-1:0]    w_mag_x, w_mag_y;
    logic [AW-1:0]    w_last;
    logic [AW-1:0]    w_nbr;
    logic             w_at_end;
    logic             w_over;
    logic             w_sqrt_busy, w_sqrt_done;

    assign w_accept = start && !busy;
    assign w_append = w_accept && (i_func == FUNC_APPEND);
    assign w_full   = (r_count == CW'(MAX_POINTS));
    assign busy     = (r_state != S_IDLE);
    assign w_last   = AW'(r_count - CW'(1));
    assign w_nbr    = r_dir ? r_cur - AW'(1) : r_cur + AW'(1);
    assign w_at_end = r_dir ? (r_cur == '0) : (r_cur == w_last);
    assign w_over   = (r_sum > SUM_W'(r_limit));

    always_comb begin
        case (r_state)
            S_ARD:   w_rd_addr = r_cur;
            S_BRD:   w_rd_addr = w_nbr;
            default: w_rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_append && !w_full) begin
            r_mem_x[r_count[AW-1:0]] <= i_coord_x[COORD_WIDTH-1:0];
            r_mem_y[r_count[AW-1:0]] <= i_coord_y[COORD_WIDTH-1:0];
        end
        r_rd_x <= r_mem_x[w_rd_addr];
        r_rd_y <= r_mem_y[w_rd_addr];
    end

    // shared subtract, magnitude and square
    assign w_dx = {r_ax[COORD_WIDTH-1], r_ax} - {r_bx[COORD_WIDTH-1], r_bx};
    assign w_dy = {r_ay[COORD_WIDTH-1], r_ay} - {r_by[COORD_WIDTH-1], r_by};
    assign w_mag_x = w_dx[DW-1] ? (~w_dx + DW'(1)) : w_dx;
    assign w_mag_y = w_dy[DW-1] ? (~w_dy + DW'(1)) : w_dy;
    assign w_sq = r_mag * r_mag;

    pcw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RGO),
        .i_value (r_acc),
        .o_busy  (w_sqrt_busy),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept && i_func == FUNC_CLIP)
                         n_state = (r_count < CW'(3)) ? S_OUT : S_SRD;
            S_SRD:   n_state = S_SLAT;
            S_SLAT:  n_state = S_DX;
            S_DX:    n_state = S_DY;
            S_DY:    n_state = S_DSUM;
            S_DSUM:  n_state = r_walking ? S_RGO : S_SCMP;
            S_SCMP:  n_state = (r_idx == w_last) ? S_WINIT : S_SRD;
            S_WINIT: n_state = S_ARD;
            S_ARD:   n_state = S_ALAT;
            S_ALAT:  n_state = S_WCHK;
            S_WCHK:  n_state = w_at_end ? S_WFIN : S_BRD;
            S_BRD:   n_state = S_BLAT;
            S_BLAT:  n_state = S_DX;
            S_RGO:   n_state = S_RWAIT;
            S_RWAIT: if (w_sqrt_done) n_state = S_WCMP;
            S_WCMP:  n_state = w_over ? S_WFIN : S_WCHK;
            S_WFIN:  n_state = r_pass ? S_OUT : S_ARD;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_fwd   <= FWD_RESET;
            r_bwd   <= BWD_RESET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_OUT);
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FWD) r_fwd <= i_cfg_data;
                else r_bwd <= i_cfg_data;
            end
            if (w_append) begin
                if (!w_full) r_count <= r_count + CW'(1);
                else r_ovf <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_func == FUNC_CLIP) begin
                    r_bx        <= i_coord_x[COORD_WIDTH-1:0];
                    r_by        <= i_coord_y[COORD_WIDTH-1:0];
                    r_idx       <= '0;
                    r_walking   <= 1'b0;
                    r_clipped   <= (r_count >= CW'(3));
                    r_start_idx <= '0;
                    r_end_idx   <= (r_count == '0) ? '0 : w_last;
                end
            end
            S_SLAT: begin
                r_ax <= r_rd_x;
                r_ay <= r_rd_y;
            end
            S_DX: r_mag <= w_mag_x;
            S_DY: begin
                r_acc <= SQ_W'(w_sq);
                r_mag <= w_mag_y;
            end
            S_DSUM: r_acc <= r_acc + SQ_W'(w_sq);
            S_SCMP: begin
                if (r_idx == '0 || r_acc < r_bestd) begin
                    r_bestd <= r_acc;
                    r_best  <= r_idx;
                end
                r_idx <= r_idx + AW'(1);
            end
            S_WINIT: begin
                r_walking <= 1'b1;
                r_pass    <= 1'b0;
                r_cur     <= r_best;
                r_dir     <= (r_bwd != '0);
                r_limit   <= r_bwd;
                r_sum     <= '0;
            end
            S_ALAT: begin
                r_ax <= r_rd_x;
                r_ay <= r_rd_y;
            end
            S_WCHK: begin
                // walk ran out of points
                if (w_at_end) r_res_idx <= r_dir ? '0 : w_last;
            end
            S_BLAT: begin
                r_bx <= r_rd_x;
                r_by <= r_rd_y;
            end
            S_RWAIT: if (w_sqrt_done) r_sum <= r_sum + SUM_W'(w_root);
            S_WCMP: begin
                if (w_over) begin
                    r_res_idx <= w_nbr;
                end else begin
                    r_cur <= w_nbr;
                    r_ax  <= r_bx;
                    r_ay  <= r_by;
                end
            end
            S_WFIN: begin
                if (r_pass) begin
                    r_end_idx <= r_res_idx;
                end else begin
                    r_start_idx <= r_res_idx;
                    r_pass      <= 1'b1;
                    r_cur       <= r_best;
                    r_dir       <= 1'b0;
                    r_limit     <= r_fwd;
                    r_sum       <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_start_index = IDX_OUT_W'(r_start_idx);
    assign o_end_index   = IDX_OUT_W'(r_end_idx);
    assign o_was_clipped = r_clipped;
    assign o_overflowed  = r_ovf;

    `include "path_clip_window_by_arc_length_assert.svh"

    `PCW_ASSERT_NXT(a_out_one_cycle, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")
    `PCW_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS), "count past cap")
    `PCW_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_state == S_IDLE, "result not idle")
    `PCW_ASSERT_IMP(a_root_free, i_clk, i_rst_n, r_state == S_RGO, !w_sqrt_busy, "root unit busy")
    `PCW_ASSERT_IMP(a_root_wait, i_clk, i_rst_n, w_sqrt_done, r_state == S_RWAIT, "stray root")
endmodule

>>> tb/tb_top.sv
// testbench for the path clip window block: directed and random point loads and clip queries
module tb_top;
    import pcw_pkg::*;

    class clip_scoreboard;
        typedef struct {
            logic [IDX_OUT_W-1:0] start_index;
            logic [IDX_OUT_W-1:0] end_index;
            logic                 was_clipped;
            logic                 overflowed;
        } t_window;

        longint   pt_x[1024];
        longint   pt_y[1024];
        int       count;
        bit       ovf;
        longint   fwd_len;
        longint   bwd_len;
        t_window  windows[$];
        int       failures;

        function new();
            count = 0;
            ovf = 0;
            fwd_len = FWD_RESET;
            bwd_len = BWD_RESET;
            failures = 0;
        endfunction

        function void set_length(logic idx, logic [LEN_W-1:0] value);
            if (idx == REG_FWD) fwd_len = value;
            else bwd_len = value;
        endfunction

        function logic [127:0] dist_sq(longint ax, longint ay, longint bx, longint by);
            longint dx;
            longint dy;
            logic [127:0] mx;
            logic [127:0] my;
            dx = ax - bx;
            dy = ay - by;
            mx = (dx < 0) ? -dx : dx;
            my = (dy < 0) ? -dy : dy;
            return mx * mx + my * my;
        endfunction

        function longint seg_len(int i, int j);
            logic [127:0] v;
            logic [127:0] r;
            logic [127:0] c;
            logic [127:0] one;
            v = dist_sq(pt_x[i], pt_y[i], pt_x[j], pt_y[j]);
            r = 0;
            one = 1;
            for (int b = 33; b >= 0; b--) begin
                c = r | (one << b);
                if (c * c <= v) r = c;
            end
            return longint'(r);
        endfunction

        function int walk_ahead(int from, longint limit);
            longint sum;
            sum = 0;
            for (int i = from; i + 1 < count; i++) begin
                sum += seg_len(i, i + 1);
                if (sum > limit) return i + 1;
            end
            return count - 1;
        endfunction

        function int walk_behind(int from, longint limit);
            longint sum;
            sum = 0;
            for (int i = from; i > 0; i--) begin
                sum += seg_len(i, i - 1);
                if (sum > limit) return i - 1;
            end
            return 0;
        endfunction

        function void note_input(logic func, logic signed [31:0] x, logic signed [31:0] y);
            t_window w;
            int nearest;
            logic [127:0] best_d;
            logic [127:0] d;
            if (func == FUNC_APPEND) begin
                if (count < 1024) begin
                    pt_x[count] = longint'(x);
                    pt_y[count] = longint'(y);
                    count++;
                end else begin
                    ovf = 1;
                end
                return;
            end
            w.start_index = 0;
            w.end_index = 0;
            w.was_clipped = 0;
            if (count < 3) begin
                w.end_index = IDX_OUT_W'((count > 0) ? count - 1 : 0);
            end else begin
                nearest = 0;
                best_d = dist_sq(pt_x[0], pt_y[0], longint'(x), longint'(y));
                for (int i = 1; i < count; i++) begin
                    d = dist_sq(pt_x[i], pt_y[i], longint'(x), longint'(y));
                    if (d < best_d) begin
                        best_d = d;
                        nearest = i;
                    end
                end
                if (bwd_len == 0) w.start_index = IDX_OUT_W'(walk_ahead(nearest, 0));
                else w.start_index = IDX_OUT_W'(walk_behind(nearest, bwd_len));
                w.end_index = IDX_OUT_W'(walk_ahead(nearest, fwd_len));
                w.was_clipped = 1;
            end
            w.overflowed = ovf;
            windows = {windows, w};
        endfunction

        function void check_result(logic [IDX_OUT_W-1:0] s, logic [IDX_OUT_W-1:0] e,
                                   logic c, logic o);
            t_window w;
            if (windows.size() == 0) begin
                $error("unexpected result start_index=%0d end_index=%0d", s, e);
                failures++;
                return;
            end
            w = windows.pop_front();
            if (s !== w.start_index) begin
                $error("start_index expected %0d actual %0d", w.start_index, s);
                failures++;
            end
            if (e !== w.end_index) begin
                $error("end_index expected %0d actual %0d", w.end_index, e);
                failures++;
            end
            if (c !== w.was_clipped) begin
                $error("was_clipped expected %0d actual %0d", w.was_clipped, c);
                failures++;
            end
            if (o !== w.overflowed) begin
                $error("overflowed expected %0d actual %0d", w.overflowed, o);
                failures++;
            end
        endfunction

        function int pending();
            return windows.size();
        endfunction
    endclass

    localparam int STALL_LIMIT = 300000;
    localparam int PATH_CAP = 24;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_func;
    logic signed [31:0]      i_coord_x;
    logic signed [31:0]      i_coord_y;
    logic                    i_cfg_we;
    logic                    i_cfg_index;
    logic [LEN_W-1:0]        i_cfg_data;
    logic                    o_valid;
    logic [IDX_OUT_W-1:0]    o_start_index;
    logic [IDX_OUT_W-1:0]    o_end_index;
    logic                    o_was_clipped;
    logic                    o_overflowed;

    clip_scoreboard windows_sb;
    int stall_cycles;
    int loaded;
    logic signed [31:0] walk_x;
    logic signed [31:0] walk_y;

    path_clip_window_by_arc_length dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_coord_x(i_coord_x),
        .i_coord_y(i_coord_y),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_start_index(o_start_index),
        .o_end_index(o_end_index),
        .o_was_clipped(o_was_clipped),
        .o_overflowed(o_overflowed)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // transfer monitor, result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) windows_sb.note_input(i_func, i_coord_x, i_coord_y);
            if (o_valid)
                windows_sb.check_result(o_start_index, o_end_index, o_was_clipped,
                                        o_overflowed);
            if ((start && !busy) || o_valid) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic func, logic signed [31:0] x, logic signed [31:0] y, int gap);
        start <= 1'b1;
        i_func <= func;
        i_coord_x <= x;
        i_coord_y <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func == FUNC_APPEND && loaded < 1024) loaded++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_length(logic idx, logic [LEN_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (windows_sb.pending() > 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        windows_sb.set_length(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {LEN_W{1'b1}};
            2: return LEN_W'($urandom_range(1, 3000));
            3: return LEN_W'($urandom_range(0, 40000));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    task automatic random_point();
        if ($urandom_range(0, 9) < 2) begin
            walk_x = $urandom;
            walk_y = $urandom;
        end else begin
            walk_x = walk_x + $signed($urandom_range(0, 8000)) - 4000;
            walk_y = walk_y + $signed($urandom_range(0, 8000)) - 4000;
        end
    endtask

    task automatic random_phase(int items);
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        for (int k = 0; k < items; k++) begin
            if (loaded < PATH_CAP && ($urandom_range(0, 3) != 0 || loaded < 3)) begin
                random_point();
                send(FUNC_APPEND, walk_x, walk_y, pick_gap());
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    qx = $urandom;
                    qy = $urandom;
                end else begin
                    qx = walk_x + $signed($urandom_range(0, 60000)) - 30000;
                    qy = walk_y + $signed($urandom_range(0, 60000)) - 30000;
                end
                send(FUNC_CLIP, qx, qy, pick_gap());
            end
        end
    endtask

    initial begin
        windows_sb = new();
        stall_cycles = 0;
        loaded = 0;
        walk_x = 0;
        walk_y = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_APPEND;
        i_coord_x = 0;
        i_coord_y = 0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_FWD;
        i_cfg_data = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short paths, extreme coordinates, ties on the nearest point
        send(FUNC_CLIP, 0, 0, 0);
        send(FUNC_APPEND, 32'sh80000000, 32'sh80000000, 1);
        send(FUNC_CLIP, 32'sh7fffffff, 32'sh7fffffff, 0);
        send(FUNC_APPEND, 32'sh7fffffff, 32'sh7fffffff, 0);
        send(FUNC_CLIP, 0, 0, 2);
        send(FUNC_APPEND, 0, 0, 0);
        send(FUNC_CLIP, 0, 0, 0);
        send(FUNC_CLIP, 32'sh7fffffff, 32'sh80000000, 0);
        send(FUNC_APPEND, 0, 0, 0);
        send(FUNC_APPEND, 3, 4, 0);
        send(FUNC_APPEND, 3, 4, 0);
        send(FUNC_CLIP, 1, 1, 0);
        send(FUNC_CLIP, 3, 4, 0);
        send(FUNC_CLIP, 32'sh80000000, 32'sh80000000, 0);
        write_length(REG_BWD, 0);
        send(FUNC_CLIP, 0, 0, 0);
        send(FUNC_CLIP, 3, 4, 0);
        write_length(REG_FWD, 0);
        send(FUNC_CLIP, 0, 0, 0);
        write_length(REG_FWD, {LEN_W{1'b1}});
        write_length(REG_BWD, {LEN_W{1'b1}});
        send(FUNC_CLIP, 3, 4, 0);
        send(FUNC_CLIP, 32'sh7fffffff, 32'sh7fffffff, 0);

        for (int p = 0; p < 8; p++) begin
            write_length(REG_FWD, pick_length());
            write_length(REG_BWD, pick_length());
            random_phase(96);
        end

        // queries at the corners with a zero backward length
        write_length(REG_BWD, 0);
        send(FUNC_CLIP, 32'sh80000000, 32'sh7fffffff, 0);
        send(FUNC_CLIP, 32'sh7fffffff, 32'sh80000000, 0);
        start <= 1'b0;

        @(posedge i_clk);
        while (windows_sb.pending() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (windows_sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
